// ===== sv/urt_pkg.sv =====
package urt_pkg;

    // Field widths
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = 5;
    localparam int ALPHA_N     = 16;
    localparam int COUNT_W     = 32;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;

    // Characters that may not appear in the alphabet
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Register indexes (paddr[4:3])
    typedef enum logic [1:0] {
        REG_RADIX      = 2'd0,
        REG_CHARS_LOW  = 2'd1,
        REG_CHARS_HIGH = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef logic [ALPHA_N-1:0][CHAR_W-1:0] chars_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        chars_t             chars;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_stat_t;

    typedef struct packed {
        logic load;
        logic run;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] digit;
        logic               quot_zero;
    } div_stat_t;

    typedef struct packed {
        logic               clear;
        logic               push;
        logic [DIGIT_W-1:0] digit;
        logic               pop_en;
        logic               bad;
    } emit_ctrl_t;

    typedef struct packed {
        logic idle;
        logic last_slot;
    } emit_stat_t;

endpackage

// ===== sv/urt_cfg.sv =====
module urt_cfg
    import urt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [CFG_DATA_W-1:0] low_reg, low_next;
    logic [CFG_DATA_W-1:0] high_reg, high_next;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[4:3]);

    // Decode writes
    always_comb
    begin
        radix_next = radix_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_RADIX:      radix_next = pwdata[RADIX_W-1:0];
                REG_CHARS_LOW:  low_next   = pwdata;
                REG_CHARS_HIGH: high_next  = pwdata;
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            REG_RADIX:      prdata = {{(CFG_DATA_W-RADIX_W){1'b0}}, radix_reg};
            REG_CHARS_LOW:  prdata = low_reg;
            REG_CHARS_HIGH: prdata = high_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
        end
        else
        begin
            radix_reg <= radix_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
        end
    end

    assign cfg.radix = radix_reg;
    assign cfg.chars = chars_t'({high_reg, low_reg});

endmodule

// ===== sv/urt_check.sv =====
module urt_check
    import urt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  cfg_t      cfg,
    output chk_stat_t stat
);

    logic       busy_reg, busy_next;
    logic [3:0] idx_reg, idx_next;
    logic       ok_reg, ok_next;

    logic [CHAR_W-1:0] cur;
    logic              in_range;
    logic              dup;
    logic              bad_here;
    logic              range_ok;

    // Test one used entry per cycle against later used entries
    always_comb
    begin
        cur      = cfg.chars[idx_reg];
        in_range = {1'b0, idx_reg} < cfg.radix;
        dup      = 1'b0;
        for (int b = 0; b < ALPHA_N; b++)
        begin
            if ((RADIX_W'(b) > {1'b0, idx_reg}) && (RADIX_W'(b) < cfg.radix)
                && (cfg.chars[4'(b)] == cur))
                dup = 1'b1;
        end
        bad_here = in_range && ((cur == CHAR_NUL) || (cur == CHAR_PLUS)
                                || (cur == CHAR_MINUS) || dup);
        range_ok = (cfg.radix >= RADIX_MIN) && (cfg.radix <= RADIX_MAX);
    end

    assign stat.done = busy_reg && (idx_reg == 4'(ALPHA_N-1));
    assign stat.ok   = ok_reg && !bad_here && range_ok;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        ok_next   = ok_reg;
        if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            ok_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            idx_next = idx_reg + 4'd1;
            ok_next  = ok_reg && !bad_here;
            if (stat.done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ok_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            ok_reg   <= ok_next;
        end
    end

endmodule

// ===== sv/urt_div.sv =====
module urt_div
    import urt_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctrl_t             ctrl,
    input  logic [VALUE_BITS-1:0] number,
    input  logic [RADIX_W-1:0]    radix,
    output div_stat_t             stat
);

    localparam int BW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [DIGIT_W-1:0]    rem_reg, rem_next;
    logic [BW-1:0]         cnt_reg, cnt_next;
    logic                  nz_reg, nz_next;

    logic [RADIX_W-1:0] trial;
    logic [RADIX_W-1:0] trial_sub;
    logic               ge;
    logic [DIGIT_W-1:0] rem_new;
    logic               last_bit;

    // One restoring-division step: shift in the next dividend bit
    assign trial     = {rem_reg, val_reg[VALUE_BITS-1]};
    assign ge        = trial >= radix;
    assign trial_sub = trial - radix;
    assign rem_new   = ge ? trial_sub[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    assign last_bit  = cnt_reg == BW'(VALUE_BITS-1);

    assign stat.done      = ctrl.run && last_bit;
    assign stat.digit     = rem_new;
    assign stat.quot_zero = !(nz_reg || ge);

    // Quotient bits shift in at the bottom as the dividend leaves the top
    always_comb
    begin
        val_next = val_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        nz_next  = nz_reg;
        if (ctrl.load)
        begin
            val_next = number;
            rem_next = '0;
            cnt_next = '0;
            nz_next  = 1'b0;
        end
        else if (ctrl.run)
        begin
            val_next = {val_reg[VALUE_BITS-2:0], ge};
            if (last_bit)
            begin
                rem_next = '0;
                cnt_next = '0;
                nz_next  = 1'b0;
            end
            else
            begin
                rem_next = rem_new;
                cnt_next = cnt_reg + 1'b1;
                nz_next  = nz_reg || ge;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
            nz_reg  <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            cnt_reg <= cnt_next;
            nz_reg  <= nz_next;
        end
    end

endmodule

// ===== sv/urt_emit.sv =====
module urt_emit
    import urt_pkg::*;
#(
    parameter int MAX_DIGITS = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  emit_ctrl_t             ctrl,
    input  chars_t                 chars,
    output emit_stat_t             stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,
    output logic                   m_tuser
);

    localparam int AW = $clog2(MAX_DIGITS);
    localparam int CW = $clog2(MAX_DIGITS + 1);

    // Digit stack: least significant digit pushed first, popped last
    logic [DIGIT_W-1:0] mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_digit_reg;

    logic [CW-1:0]      sp_reg, sp_next;
    logic               stage_valid_reg, stage_valid_next;
    logic               stage_last_reg, stage_last_next;
    logic               bad_reg, bad_next;
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               inv_reg, inv_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    logic               out_free;
    logic               take_stage;
    logic               take_bad;
    logic               do_pop;
    logic [CW-1:0]      sp_m1;
    logic [COUNT_W-1:0] count_inc;

    assign out_free   = !out_valid_reg || m_tready;
    assign take_stage = stage_valid_reg && out_free;
    assign take_bad   = bad_reg && out_free;
    assign do_pop     = ctrl.pop_en && (sp_reg != '0) && (!stage_valid_reg || take_stage);
    assign sp_m1      = sp_reg - 1'b1;
    assign count_inc  = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    assign stat.idle      = (sp_reg == '0) && !stage_valid_reg && !bad_reg;
    assign stat.last_slot = sp_reg == CW'(MAX_DIGITS - 1);

    // Stack pointer and read stage
    always_comb
    begin
        sp_next          = sp_reg;
        stage_valid_next = stage_valid_reg;
        stage_last_next  = stage_last_reg;
        bad_next         = bad_reg;
        if (ctrl.clear)
            sp_next = '0;
        else if (ctrl.push)
            sp_next = sp_reg + 1'b1;
        else if (do_pop)
            sp_next = sp_m1;
        if (do_pop)
        begin
            stage_valid_next = 1'b1;
            stage_last_next  = sp_reg == CW'(1);
        end
        else if (take_stage)
            stage_valid_next = 1'b0;
        if (ctrl.bad)
            bad_next = 1'b1;
        else if (take_bad)
            bad_next = 1'b0;
    end

    // Output word register and running count
    always_comb
    begin
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        inv_next       = inv_reg;
        total_next     = total_reg;
        count_next     = count_reg;
        if (take_stage)
        begin
            out_valid_next = 1'b1;
            char_next      = chars[rd_digit_reg];
            last_next      = stage_last_reg;
            inv_next       = 1'b0;
            total_next     = count_inc;
            count_next     = count_inc;
        end
        else if (take_bad)
        begin
            out_valid_next = 1'b1;
            char_next      = CHAR_NUL;
            last_next      = 1'b1;
            inv_next       = 1'b1;
            total_next     = count_reg;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
            mem[sp_reg[AW-1:0]] <= ctrl.digit;
        if (do_pop)
            rd_digit_reg <= mem[sp_m1[AW-1:0]];
        char_reg  <= char_next;
        last_reg  <= last_next;
        inv_reg   <= inv_next;
        total_reg <= total_next;
        stage_last_reg <= stage_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg          <= '0;
            stage_valid_reg <= 1'b0;
            bad_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            sp_reg          <= sp_next;
            stage_valid_reg <= stage_valid_next;
            bad_reg         <= bad_next;
            out_valid_reg   <= out_valid_next;
            count_reg       <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {total_reg, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = inv_reg;

endmodule

// ===== sv/unsigned_to_custom_radix_text.sv =====
// Unsigned number to text in a programmable radix.
// Input stream: one word per number in s_tdata. Output stream: one word per
// digit character, most significant digit first; m_tlast marks the final
// character of a number. m_tuser flags an invalid radix or alphabet, in which case a
// single word with character 0 and m_tlast set is sent instead of digits.
// m_tdata also carries the saturating running character count.
// Software sets the radix and the 16-character alphabet over the APB port
// before streaming; after reset the radix is 0, so every number reports
// invalid until the radix and the alphabet are programmed.
// Per number: the alphabet is scanned (one entry per cycle), each digit is the
// remainder of a bit-serial restoring division by the radix, and the digit
// stack is then drained to the output, most significant digit first.
// One number is converted at a time; s_tready is high only between numbers.
// The output word register lets the next number be taken while the last
// character still waits; a stalled receiver holds the output word and
// pauses the digit stack.
module unsigned_to_custom_radix_text
    import urt_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_DIGITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [CFG_ADDR_W-1:0]             paddr,
    input  logic [CFG_DATA_W-1:0]             pwdata,
    output logic [CFG_DATA_W-1:0]             prdata,
    output logic                              pready,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_tdata,  // number
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_TDATA_W-1:0]            m_tdata,  // character[7:0], total_chars[39:8]
    output logic                              m_tlast,
    output logic                              m_tuser   // invalid
);

    cfg_t       cfg;
    chk_stat_t  chk_stat;
    div_ctrl_t  div_ctrl;
    div_stat_t  div_stat;
    emit_ctrl_t emit_ctrl;
    emit_stat_t emit_stat;
    logic       chk_start;
    logic       accept;

    state_t state_reg, state_next;

    urt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    urt_check u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .start (chk_start),
        .cfg   (cfg),
        .stat  (chk_stat)
    );

    urt_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (div_ctrl),
        .number (s_tdata[VALUE_BITS-1:0]),
        .radix  (cfg.radix),
        .stat   (div_stat)
    );

    urt_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (emit_ctrl),
        .chars    (cfg.chars),
        .stat     (emit_stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    assign s_tready = state_reg == ST_IDLE;
    assign accept   = s_tvalid && s_tready;

    // Sequence check, divide (skipped for an invalid configuration) and emit for one number
    always_comb
    begin
        state_next      = state_reg;
        chk_start       = 1'b0;
        div_ctrl.load   = 1'b0;
        div_ctrl.run    = 1'b0;
        emit_ctrl.clear = 1'b0;
        emit_ctrl.push  = 1'b0;
        emit_ctrl.digit = div_stat.digit;
        emit_ctrl.pop_en = 1'b0;
        emit_ctrl.bad   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    chk_start       = 1'b1;
                    div_ctrl.load   = 1'b1;
                    emit_ctrl.clear = 1'b1;
                    state_next      = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (chk_stat.done)
                begin
                    if (chk_stat.ok)
                        state_next = ST_DIVIDE;
                    else
                    begin
                        emit_ctrl.bad = 1'b1;
                        state_next    = ST_EMIT;
                    end
                end
            end
            ST_DIVIDE:
            begin
                div_ctrl.run = 1'b1;
                if (div_stat.done)
                begin
                    emit_ctrl.push = 1'b1;
                    if (div_stat.quot_zero || emit_stat.last_slot)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                emit_ctrl.pop_en = 1'b1;
                if (emit_stat.idle)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/urt_sva.sv =====
module urt_sva
    import urt_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast,
    input logic                   m_tuser
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // Invalid report is a single zero character closing the number
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata[CHAR_W-1:0] == CHAR_NUL))
        else $error("invalid word not last or not zero");

    // A valid alphabet never yields a zero, plus or minus character
    a_good_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[CHAR_W-1:0] != CHAR_NUL)
                                 && (m_tdata[CHAR_W-1:0] != CHAR_PLUS)
                                 && (m_tdata[CHAR_W-1:0] != CHAR_MINUS))
        else $error("forbidden digit character");

    // One number in flight: no input taken right after one is accepted
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while converting");

endmodule

bind unsigned_to_custom_radix_text urt_sva u_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
